// File: rtl/qvr_pkg.sv
// Shared widths, angle constants and elaboration-time constant functions for the rotation block.
package qvr_pkg;

	localparam int DATA_WIDTH_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// CORDIC datapath width (Q30 with headroom for the folded half angle)
	localparam int CW = 34;
	// Q24 quaternion parts, Q24 first product, Q24 result
	localparam int QW = 28;
	localparam int TW = 31;
	localparam int RW = 34;

	localparam logic signed [63:0] PI_Q30         = 64'sd3373259426;
	localparam logic signed [63:0] HALF_PI_Q30    = 64'sd1686629713;
	localparam logic signed [63:0] QUARTER_PI_Q30 = 64'sd843314857;

	// Restoring division, used only to build constants.
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bitv;
		n = n_in;
		res = '0;
		bitv = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (bitv > n) bitv = bitv >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (bitv != 0) begin
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
		end
		return res;
	endfunction

	// atan(2^-i) in Q30: Taylor series in Q60, each term truncated, then rounded.
	function automatic logic signed [63:0] atan_q30(input int i);
		logic signed [63:0] sum;
		logic signed [63:0] term;
		int e;
		sum = '0;
		if (i == 0) return QUARTER_PI_Q30;
		for (int k = 0; k < 31; k++) begin
			e = 60 - i * (2 * k + 1);
			if (e >= 0) begin
				term = signed'(udiv(64'd1 << e, 64'(2 * k + 1)));
				sum = k[0] ? sum - term : sum + term;
			end
		end
		return (sum + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// 1/G in Q30, rounded, for a CORDIC of n stages.
	function automatic logic signed [63:0] cordic_start(input int n);
		logic [63:0] p;
		logic [63:0] g;
		p = 64'd1 << 60;
		for (int i = 0; i < 32; i++) begin
			if (i < n) p = p + (p >> (2 * i));
		end
		g = isqrt(p);
		return signed'(udiv((64'd1 << 60) + (g >> 1), g));
	endfunction

	// Round a Q48 product sum to Q24, ties toward plus infinity.
	function automatic logic signed [63:0] rnd24(input logic signed [63:0] v);
		return (v + (64'sd1 <<< 23)) >>> 24;
	endfunction

endpackage

// File: rtl/qvr_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per iteration, with side data carried along.
module qvr_cordic #(
	parameter int STAGES = qvr_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 6 * qvr_pkg::DATA_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [qvr_pkg::CW-1:0]   in_h,
	input  logic                            in_flip,
	input  logic        [SIDE_W-1:0]        in_side,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [qvr_pkg::CW-1:0]   out_x,
	output logic signed [qvr_pkg::CW-1:0]   out_y,
	output logic                            out_flip,
	output logic        [SIDE_W-1:0]        out_side
);
	import qvr_pkg::*;

	localparam logic signed [CW-1:0] X0 = CW'(cordic_start(STAGES));

	logic                       vld_s  [STAGES];
	logic [STAGES-1:0]          adv;
	logic signed [CW-1:0]       x_s    [STAGES];
	logic signed [CW-1:0]       y_s    [STAGES];
	logic signed [CW-1:0]       h_s    [STAGES-1];
	logic                       flip_s [STAGES];
	logic [SIDE_W-1:0]          side_s [STAGES];

	assign in_ready = adv[0];

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		localparam logic signed [CW-1:0] ATAN = CW'(atan_q30(i));
		logic signed [CW-1:0] x_in, y_in, h_in;
		logic                 f_in;
		logic [SIDE_W-1:0]    s_in;
		logic                 v_in;
		logic                 dir;

		if (i == 0) begin : g_first
			assign x_in = X0;
			assign y_in = '0;
			assign h_in = in_h;
			assign f_in = in_flip;
			assign s_in = in_side;
			assign v_in = in_valid;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign h_in = h_s[i-1];
			assign f_in = flip_s[i-1];
			assign s_in = side_s[i-1];
			assign v_in = vld_s[i-1];
		end

		if (i == STAGES - 1) begin : g_adv_last
			assign adv[i] = !vld_s[i] || out_ready;
		end else begin : g_adv
			assign adv[i] = !vld_s[i] || adv[i+1];
		end

		assign dir = !h_in[CW-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv[i]) begin
				vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[i]) begin
				x_s[i]    <= dir ? x_in - (y_in >>> i) : x_in + (y_in >>> i);
				y_s[i]    <= dir ? y_in + (x_in >>> i) : y_in - (x_in >>> i);
				flip_s[i] <= f_in;
				side_s[i] <= s_in;
			end
		end

		if (i < STAGES - 1) begin : g_h
			always_ff @(posedge clk) begin
				if (adv[i]) h_s[i] <= dir ? h_in - ATAN : h_in + ATAN;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign out_x     = x_s[STAGES-1];
	assign out_y     = y_s[STAGES-1];
	assign out_flip  = flip_s[STAGES-1];
	assign out_side  = side_s[STAGES-1];

endmodule

// File: rtl/quaternion_vector_rotation.sv
// Top level: fold, CORDIC sine/cosine, and the two pipelined quaternion products.
// A request passes s1, the CORDIC stages and s2 to s8 in order before it shows on m_tvalid.
// Throughput: one request per cycle unless m_tready stalls; CORDIC and product stages pipeline.
// Every stage advances when its successor is empty or advancing, so bubbles close up under stall.
// Reset (arst_n low) clears all stage valid bits at once; payload registers are not reset.
module quaternion_vector_rotation #(
	parameter int DATA_WIDTH    = qvr_pkg::DATA_WIDTH_DEF,
	parameter int CORDIC_STAGES = qvr_pkg::CORDIC_STAGES_DEF,
	localparam int S_W = ((7 * DATA_WIDTH + 7) / 8) * 8,
	localparam int M_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z, zero pad
	input  logic [S_W-1:0] s_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	// rot_x, rot_y, rot_z, zero pad
	output logic [M_W-1:0] m_tdata
);
	import qvr_pkg::*;

	localparam int DW     = DATA_WIDTH;
	localparam int FIN    = DW - 2;
	localparam int SIDE_W = 6 * DW;
	localparam int ANG_SHL = 30 - FIN;
	localparam int IN_SHL  = (FIN <= 24) ? 24 - FIN : 0;
	localparam int IN_SHR  = (FIN > 24) ? FIN - 24 : 0;
	localparam logic signed [63:0] IN_RND  = (64'sd1 <<< IN_SHR) >>> 1;
	localparam int OUT_SHL = (FIN >= 24) ? FIN - 24 : 0;
	localparam int OUT_SHR = (FIN < 24) ? 24 - FIN : 0;
	localparam logic signed [63:0] OUT_RND = (64'sd1 <<< OUT_SHR) >>> 1;
	localparam logic signed [63:0] SAT_HI  = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO  = -SAT_HI - 64'sd1;

	// Input Q(DW-2) to Q24, rounded when narrowing.
	function automatic logic signed [QW-1:0] to_q24(input logic signed [DW-1:0] v);
		logic signed [63:0] t;
		t = 64'(v) <<< IN_SHL;
		t = (t + IN_RND) >>> IN_SHR;
		return t[QW-1:0];
	endfunction

	// Q24 result to output format, then clamp to the signed output range.
	function automatic logic [DW-1:0] to_out(input logic signed [RW-1:0] v);
		logic signed [63:0] t;
		t = 64'(v) <<< OUT_SHL;
		t = (t + OUT_RND) >>> OUT_SHR;
		if (t > SAT_HI) t = SAT_HI;
		if (t < SAT_LO) t = SAT_LO;
		return t[DW-1:0];
	endfunction

	// Stage advance chain: a stage loads when empty or when its successor moves.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7, adv_s8;
	logic cor_ready, cor_valid;

	assign adv_s8 = !v_s8 || m_tready;
	assign adv_s7 = !v_s7 || adv_s8;
	assign adv_s6 = !v_s6 || adv_s7;
	assign adv_s5 = !v_s5 || adv_s6;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || cor_ready;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= s_tvalid;
			if (adv_s2) v_s2 <= cor_valid;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
			if (adv_s7) v_s7 <= v_s6;
			if (adv_s8) v_s8 <= v_s7;
		end
	end

	// ---- s1: take the angle as the half angle in Q30 and fold it into +-pi/2
	logic signed [DW-1:0]   ang_in;
	logic signed [63:0]     ang_q30;
	logic signed [63:0]     h_fold;
	logic                   flip_fold;
	logic signed [CW-1:0]   h_s1;
	logic                   flip_s1;
	logic [SIDE_W-1:0]      side_s1;

	assign ang_in  = s_tdata[DW-1:0];
	assign ang_q30 = 64'(ang_in) <<< ANG_SHL;

	always_comb begin
		h_fold    = ang_q30;
		flip_fold = 1'b0;
		if (ang_q30 > HALF_PI_Q30) begin
			h_fold    = ang_q30 - PI_Q30;
			flip_fold = 1'b1;
		end else if (ang_q30 < -HALF_PI_Q30) begin
			h_fold    = ang_q30 + PI_Q30;
			flip_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			h_s1    <= h_fold[CW-1:0];
			flip_s1 <= flip_fold;
			side_s1 <= s_tdata[7*DW-1:DW];
		end
	end

	// ---- CORDIC: sine in y, cosine in x
	logic signed [CW-1:0] cor_x, cor_y;
	logic                 cor_flip;
	logic [SIDE_W-1:0]    cor_side;

	qvr_cordic #(
		.STAGES (CORDIC_STAGES),
		.SIDE_W (SIDE_W)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (cor_ready),
		.in_h      (h_s1),
		.in_flip   (flip_s1),
		.in_side   (side_s1),
		.out_valid (cor_valid),
		.out_ready (adv_s2),
		.out_x     (cor_x),
		.out_y     (cor_y),
		.out_flip  (cor_flip),
		.out_side  (cor_side)
	);

	// ---- s2: undo the fold, round sin/cos to Q24, bring axis and vector to Q24
	logic signed [CW-1:0] sin_f, cos_f;
	logic signed [CW-1:0] sin_r, cos_r;
	logic signed [QW-1:0] sin_s2, cos_s2;
	logic signed [QW-1:0] ax_s2, ay_s2, az_s2, vx_s2, vy_s2, vz_s2;

	assign sin_f = cor_flip ? -cor_y : cor_y;
	assign cos_f = cor_flip ? -cor_x : cor_x;
	assign sin_r = (sin_f + CW'(32)) >>> 6;
	assign cos_r = (cos_f + CW'(32)) >>> 6;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sin_s2 <= sin_r[QW-1:0];
			cos_s2 <= cos_r[QW-1:0];
			ax_s2  <= to_q24(cor_side[0*DW +: DW]);
			ay_s2  <= to_q24(cor_side[1*DW +: DW]);
			az_s2  <= to_q24(cor_side[2*DW +: DW]);
			vx_s2  <= to_q24(cor_side[3*DW +: DW]);
			vy_s2  <= to_q24(cor_side[4*DW +: DW]);
			vz_s2  <= to_q24(cor_side[5*DW +: DW]);
		end
	end

	// ---- s3: quaternion vector part q = axis * sin
	logic signed [2*QW-1:0] qx_p, qy_p, qz_p;
	logic signed [63:0]   qx_r, qy_r, qz_r;
	logic signed [QW-1:0] qx_s3, qy_s3, qz_s3, qw_s3;
	logic signed [QW-1:0] vx_s3, vy_s3, vz_s3;

	assign qx_p = ax_s2 * sin_s2;
	assign qy_p = ay_s2 * sin_s2;
	assign qz_p = az_s2 * sin_s2;
	assign qx_r = rnd24(64'(qx_p));
	assign qy_r = rnd24(64'(qy_p));
	assign qz_r = rnd24(64'(qz_p));

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			qx_s3 <= qx_r[QW-1:0];
			qy_s3 <= qy_r[QW-1:0];
			qz_s3 <= qz_r[QW-1:0];
			qw_s3 <= cos_s2;
			vx_s3 <= vx_s2;
			vy_s3 <= vy_s2;
			vz_s3 <= vz_s2;
		end
	end

	// ---- s4: partial products of t = q * (v, 0)
	logic signed [2*QW-1:0] pw_s4 [3];
	logic signed [2*QW-1:0] px_s4 [3];
	logic signed [2*QW-1:0] py_s4 [3];
	logic signed [2*QW-1:0] pz_s4 [3];
	logic signed [QW-1:0]   qx_s4, qy_s4, qz_s4, qw_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			pw_s4[0] <= qx_s3 * vx_s3;
			pw_s4[1] <= qy_s3 * vy_s3;
			pw_s4[2] <= qz_s3 * vz_s3;
			px_s4[0] <= qw_s3 * vx_s3;
			px_s4[1] <= qy_s3 * vz_s3;
			px_s4[2] <= qz_s3 * vy_s3;
			py_s4[0] <= qw_s3 * vy_s3;
			py_s4[1] <= qz_s3 * vx_s3;
			py_s4[2] <= qx_s3 * vz_s3;
			pz_s4[0] <= qw_s3 * vz_s3;
			pz_s4[1] <= qx_s3 * vy_s3;
			pz_s4[2] <= qy_s3 * vx_s3;
			qx_s4 <= qx_s3;
			qy_s4 <= qy_s3;
			qz_s4 <= qz_s3;
			qw_s4 <= qw_s3;
		end
	end

	// ---- s5: sum and round t
	logic signed [63:0]   tw_r, tx_r, ty_r, tz_r;
	logic signed [TW-1:0] tw_s5, tx_s5, ty_s5, tz_s5;
	logic signed [QW-1:0] qx_s5, qy_s5, qz_s5, qw_s5;

	assign tw_r = rnd24(-(64'(pw_s4[0]) + 64'(pw_s4[1]) + 64'(pw_s4[2])));
	assign tx_r = rnd24(64'(px_s4[0]) + 64'(px_s4[1]) - 64'(px_s4[2]));
	assign ty_r = rnd24(64'(py_s4[0]) + 64'(py_s4[1]) - 64'(py_s4[2]));
	assign tz_r = rnd24(64'(pz_s4[0]) + 64'(pz_s4[1]) - 64'(pz_s4[2]));

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			tw_s5 <= tw_r[TW-1:0];
			tx_s5 <= tx_r[TW-1:0];
			ty_s5 <= ty_r[TW-1:0];
			tz_s5 <= tz_r[TW-1:0];
			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
			qz_s5 <= qz_s4;
			qw_s5 <= qw_s4;
		end
	end

	// ---- s6: partial products of r = t * conj(q)
	logic signed [TW+QW-1:0] rpx_s6 [4];
	logic signed [TW+QW-1:0] rpy_s6 [4];
	logic signed [TW+QW-1:0] rpz_s6 [4];

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			rpx_s6[0] <= tw_s5 * qx_s5;
			rpx_s6[1] <= tx_s5 * qw_s5;
			rpx_s6[2] <= ty_s5 * qz_s5;
			rpx_s6[3] <= tz_s5 * qy_s5;
			rpy_s6[0] <= tw_s5 * qy_s5;
			rpy_s6[1] <= ty_s5 * qw_s5;
			rpy_s6[2] <= tz_s5 * qx_s5;
			rpy_s6[3] <= tx_s5 * qz_s5;
			rpz_s6[0] <= tw_s5 * qz_s5;
			rpz_s6[1] <= tz_s5 * qw_s5;
			rpz_s6[2] <= tx_s5 * qy_s5;
			rpz_s6[3] <= ty_s5 * qx_s5;
		end
	end

	// ---- s7: sum and round r to Q24
	logic signed [63:0]   rx_r, ry_r, rz_r;
	logic signed [RW-1:0] rx_s7, ry_s7, rz_s7;

	assign rx_r = rnd24(-64'(rpx_s6[0]) + 64'(rpx_s6[1]) - (64'(rpx_s6[2]) - 64'(rpx_s6[3])));
	assign ry_r = rnd24(-64'(rpy_s6[0]) + 64'(rpy_s6[1]) - (64'(rpy_s6[2]) - 64'(rpy_s6[3])));
	assign rz_r = rnd24(-64'(rpz_s6[0]) + 64'(rpz_s6[1]) - (64'(rpz_s6[2]) - 64'(rpz_s6[3])));

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			rx_s7 <= rx_r[RW-1:0];
			ry_s7 <= ry_r[RW-1:0];
			rz_s7 <= rz_r[RW-1:0];
		end
	end

	// ---- s8: rescale, saturate, hold for the output handshake
	logic [3*DW-1:0] out_s8;

	always_ff @(posedge clk) begin
		if (adv_s8) begin
			out_s8 <= {to_out(rz_s7), to_out(ry_s7), to_out(rx_s7)};
		end
	end

	assign m_tvalid = v_s8;
	assign m_tdata  = M_W'(out_s8);

`ifndef SYNTH
	// Input is refused only when every stage holds a request.
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7 && v_s8))
		else $error("input blocked while a stage is empty");
	// The output stage takes exactly what stage seven held.
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s8 |=> (v_s8 == $past(v_s7)))
		else $error("output valid lost or invented");
	// A blocked stage seven keeps its result.
	a_s7_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !adv_s7) |=> (v_s7 && $stable(rx_s7) && $stable(ry_s7) && $stable(rz_s7)))
		else $error("stalled result changed");
`endif

endmodule

// File: tb/qvr_checker.sv
// Checker for the rotation block: predicts each request's rotated vector and compares results.
`timescale 1ns / 100ps
module qvr_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [47:0]  m_tdata,
	output int           fail_count,
	output int           pending
);

	localparam int STAGES = 16;
	localparam longint PI30      = 64'sd3373259426;
	localparam longint HALF_PI30 = 64'sd1686629713;
	localparam longint QTR_PI30  = 64'sd843314857;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} rot_vec_t;

	rot_vec_t rotated_q[$];
	longint atan_tab[STAGES];
	longint gain_inv;

	function automatic longint rshift_rnd(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Build the arctangent table and the CORDIC start value once.
	initial begin
		longint unsigned p, g;
		longint acc, term;
		atan_tab[0] = QTR_PI30;
		for (int i = 1; i < STAGES; i++) begin
			acc = 0;
			for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
				term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
				acc = k[0] ? acc - term : acc + term;
			end
			atan_tab[i] = (acc + (64'sd1 <<< 29)) >>> 30;
		end
		p = 64'd1 << 60;
		for (int i = 0; i < STAGES; i++) p = p + (p >> (2 * i));
		g = root64(p);
		gain_inv = longint'(((64'd1 << 60) + g / 2) / g);
	end

	function automatic logic signed [15:0] clamp16(longint v);
		longint r;
		r = rshift_rnd(v, 10);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic rot_vec_t rotate_vector(logic [111:0] d);
		longint h, cx, cy, dx, dy, s, c;
		longint ax, ay, az, vx, vy, vz, qx, qy, qz, qw;
		longint tw, tx, ty, tz, rx, ry, rz;
		bit flip;
		rot_vec_t r;
		// angle in Q13 is the half angle in Q14; widen to Q30
		h = longint'($signed(d[15:0])) <<< 16;
		flip = 0;
		if (h > HALF_PI30) begin
			h = h - PI30;
			flip = 1;
		end else if (h < -HALF_PI30) begin
			h = h + PI30;
			flip = 1;
		end
		cx = gain_inv;
		cy = 0;
		for (int i = 0; i < STAGES; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (h >= 0) begin
				cx = cx - dx; cy = cy + dy; h = h - atan_tab[i];
			end else begin
				cx = cx + dx; cy = cy - dy; h = h + atan_tab[i];
			end
		end
		if (flip) begin
			cx = -cx; cy = -cy;
		end
		s = rshift_rnd(cy, 6);
		c = rshift_rnd(cx, 6);
		ax = longint'($signed(d[31:16])) <<< 10;
		ay = longint'($signed(d[47:32])) <<< 10;
		az = longint'($signed(d[63:48])) <<< 10;
		vx = longint'($signed(d[79:64])) <<< 10;
		vy = longint'($signed(d[95:80])) <<< 10;
		vz = longint'($signed(d[111:96])) <<< 10;
		qx = rshift_rnd(ax * s, 24);
		qy = rshift_rnd(ay * s, 24);
		qz = rshift_rnd(az * s, 24);
		qw = c;
		tw = rshift_rnd(-(qx * vx + qy * vy + qz * vz), 24);
		tx = rshift_rnd(qw * vx + qy * vz - qz * vy, 24);
		ty = rshift_rnd(qw * vy + qz * vx - qx * vz, 24);
		tz = rshift_rnd(qw * vz + qx * vy - qy * vx, 24);
		rx = rshift_rnd(-tw * qx + qw * tx - (ty * qz - tz * qy), 24);
		ry = rshift_rnd(-tw * qy + qw * ty - (tz * qx - tx * qz), 24);
		rz = rshift_rnd(-tw * qz + qw * tz - (tx * qy - ty * qx), 24);
		r.x = clamp16(rx);
		r.y = clamp16(ry);
		r.z = clamp16(rz);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rot_vec_t want, got;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (s_tvalid && s_tready) rotated_q.push_back(rotate_vector(s_tdata));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (rotated_q.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = rotated_q.pop_front();
					if (want.x !== got.x) $error("rot_x expected %0d got %0d", want.x, got.x);
					if (want.y !== got.y) $error("rot_y expected %0d got %0d", want.y, got.y);
					if (want.z !== got.z) $error("rot_z expected %0d got %0d", want.z, got.z);
					if (want !== got) fail_count <= fail_count + 1;
				end
			end
			pending <= rotated_q.size();
		end
	end

endmodule

// File: tb/tb_quaternion_vector_rotation.sv
// Testbench top for the rotation block: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_quaternion_vector_rotation;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;   // angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;   // rot_x, rot_y, rot_z
	int           fail_count;
	int           pending;
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           phase;
	int           hold_left;
	bit           hold_done;

	quaternion_vector_rotation uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	qvr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Receiver: random stalls per phase; in the last phase hold off once for a long
	// stretch so the pipeline fills and back-pressures the sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (phase == 2 && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= 150;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one request, hold it until accepted, then maybe drop valid and idle at random.
	task automatic send_request(input logic [15:0] ang, input logic [15:0] ax,
			input logic [15:0] ay, input logic [15:0] az, input logic [15:0] vx,
			input logic [15:0] vy, input logic [15:0] vz);
		s_tdata  <= {vz, vy, vx, az, ay, ax, ang};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Mostly unit-length axes with random content; the rest raw random fields.
	task automatic send_random();
		real rx, ry, rz, n;
		logic [15:0] ax, ay, az;
		if ($urandom_range(99) < 70) begin
			rx = real'($signed($urandom_range(65535) - 32768));
			ry = real'($signed($urandom_range(65535) - 32768));
			rz = real'($signed($urandom_range(65535) - 32768));
			n = $sqrt(rx * rx + ry * ry + rz * rz);
			if (n < 1.0) n = 1.0;
			ax = 16'($rtoi(rx / n * 16383.0));
			ay = 16'($rtoi(ry / n * 16383.0));
			az = 16'($rtoi(rz / n * 16383.0));
		end else begin
			ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
		end
		send_request(16'($urandom), ax, ay, az, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		phase       = 0;
		tx_idle_pct = 11;
		rx_idle_pct = 75;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero angle, angle extremes, +-pi, unit axes, zero axis,
		// oversized axis (saturates), vector extremes
		send_request(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h4000);
		send_request(16'h7FFF, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_request(16'h8000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
		send_request(16'd25736, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000);
		send_request(-16'sd25736, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000, 16'h0000);
		send_request(16'd12868, 16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000);
		send_request(16'd12868, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h4000);
		send_request(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
		send_request(16'd12868, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_request(16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		send_request(16'h0001, 16'hC000, 16'h0000, 16'h0000, 16'h0000, 16'hC000, 16'h4000);
		send_request(16'hFFFF, 16'h2D41, 16'h2D41, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000);
		send_request(16'd6434, 16'h24F3, 16'h24F3, 16'h24F3, 16'h4000, 16'h0000, 16'hC000);

		for (int i = 0; i < 700; i++) begin
			if (i == 233) begin
				phase = 1; tx_idle_pct = 75; rx_idle_pct = 11;
			end else if (i == 466) begin
				phase = 2; tx_idle_pct = 0; rx_idle_pct = 0;
			end
			send_random();
		end
		s_tvalid <= 1'b0;

		// drain, then allow the pipeline latency to expose any stray result
		for (int w = 0; w < 20000 && pending != 0; w++) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("quaternion_vector_rotation regression: pass");
		else
			$display("quaternion_vector_rotation regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("quaternion_vector_rotation regression: fail");
		$finish;
	end

endmodule
